/* sv/assert_macros.svh */
// assertion macros shared by the fee-rate histogram rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on clk_i, masked while rst_ni is low
`define FRH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on clk_i, also during reset
`define FRH_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/frh_pkg.sv */
// shared types, constants and helpers of the fee-rate histogram
`timescale 1ns / 1ps

package frh_pkg;

  localparam int unsigned FEE_BITS       = 52;
  localparam int unsigned LABEL_BITS     = 52;
  localparam int unsigned OUT_TOTAL_BITS = 48;

  localparam int unsigned DEF_NUM_BINS   = 53;
  localparam int unsigned DEF_SIZE_BITS  = 26;
  localparam int unsigned DEF_TOTAL_BITS = 48;

  // divider step counter and bin number widths
  localparam int unsigned CNT_W = $clog2(FEE_BITS);
  localparam int unsigned KW    = CNT_W + 1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_e;

  // label 2^k-1, all ones once k reaches the label width
  function automatic logic [LABEL_BITS-1:0] bin_label(input logic [KW-1:0] k);
    logic [63:0] m;
    m = (64'd1 << k) - 64'd1;
    return m[LABEL_BITS-1:0];
  endfunction

endpackage

/* sv/fee_rate_log2_histogram.sv */
// fee-rate histogram top level: sequencer, bin total memory and update unit
// add / remove: wait for the serial divider (one quotient bit a cycle), then read and update the bin
// dump: one memory read a cycle over all bins; at most one result strobe a cycle
// busy is high for the whole transaction; a new start is taken once it falls
// reset clears the present flags at once, so no clearing pass; totals need none
// results are strobed for one cycle and cannot be stalled by the receiver
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fee_rate_log2_histogram #(
  parameter int unsigned NUM_BINS   = frh_pkg::DEF_NUM_BINS,
  parameter int unsigned SIZE_BITS  = frh_pkg::DEF_SIZE_BITS,
  parameter int unsigned TOTAL_BITS = frh_pkg::DEF_TOTAL_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command_i,
  input  logic signed [frh_pkg::FEE_BITS-1:0] fee_amount_i,
  input  logic [SIZE_BITS-1:0]               tx_size_i,
  output logic                               result_valid_o,
  output logic [frh_pkg::LABEL_BITS-1:0]     bucket_label_o,
  output logic [frh_pkg::OUT_TOTAL_BITS-1:0] bucket_total_o,
  output logic                               is_last_o,
  output logic                               is_empty_o
);

  localparam int unsigned BinW = $clog2(NUM_BINS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_UPD,
    ST_DUMP,
    ST_DTAIL,
    ST_DFIN
  } state_e;

  state_e                      state_q;
  frh_pkg::cmd_e               cmd_q;
  logic [SIZE_BITS-1:0]        size_q;
  logic [BinW-1:0]             k_q;
  logic [NUM_BINS-1:0]         present_q;

  // dump walk
  logic [BinW-1:0]             scan_idx_q;
  logic [BinW-1:0]             scan_prev_q;
  logic                        scan_vld_q;
  logic                        pend_vld_q;
  logic [BinW-1:0]             pend_idx_q;
  logic [TOTAL_BITS-1:0]       pend_total_q;

  // result registers
  logic                        res_vld_q;
  logic [frh_pkg::LABEL_BITS-1:0] res_label_q;
  logic [TOTAL_BITS-1:0]       res_total_q;
  logic                        res_last_q;
  logic                        res_empty_q;

  // bin total memory
  logic [TOTAL_BITS-1:0]       mem_q [NUM_BINS];
  logic [TOTAL_BITS-1:0]       rd_data_q;
  logic [BinW-1:0]             rd_addr;
  logic                        wr_en;
  logic [TOTAL_BITS-1:0]       wr_data;

  // divider hookup
  logic                        div_start;
  logic                        div_done;
  logic [BinW-1:0]             div_bin;

  // shared add / subtract unit
  logic [TOTAL_BITS-1:0]       cur_total;
  logic [TOTAL_BITS:0]         alu_a;
  logic [TOTAL_BITS:0]         alu_b;
  logic                        alu_sub;
  logic [TOTAL_BITS:0]         alu_y;
  logic                        rm_clear;
  logic                        dump_hit;
  logic [63:0]                 res_total_w;

  logic                        accept;
  assign accept = start && !busy;

  // only add and remove need the rate bin
  assign div_start = accept &&
                     (command_i == frh_pkg::CMD_ADD || command_i == frh_pkg::CMD_REMOVE);

  frh_rate_bin #(
    .NUM_BINS  (NUM_BINS),
    .SIZE_BITS (SIZE_BITS)
  ) u_rate_bin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .fee_i   (fee_amount_i),
    .size_i  (tx_size_i),
    .done_o  (div_done),
    .bin_o   (div_bin)
  );

  // an absent bin reads as zero, whatever the memory holds
  assign cur_total = present_q[k_q] ? rd_data_q : '0;
  assign alu_sub   = (cmd_q == frh_pkg::CMD_REMOVE);
  assign alu_a     = {1'b0, cur_total};
  assign alu_b     = {1'b0, TOTAL_BITS'(size_q)};
  assign alu_y     = alu_a + (alu_b ^ {(TOTAL_BITS + 1){alu_sub}})
                   + {{TOTAL_BITS{1'b0}}, alu_sub};

  // remove clears when the total would reach zero or go below
  assign rm_clear = alu_y[TOTAL_BITS] || (alu_y[TOTAL_BITS-1:0] == '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = alu_y[TOTAL_BITS-1:0];
    if (state_q == ST_UPD) begin
      case (cmd_q)
        frh_pkg::CMD_ADD: begin
          wr_en = 1'b1;
          // carry out means the total saturates
          if (alu_y[TOTAL_BITS]) begin
            wr_data = '1;
          end
        end
        frh_pkg::CMD_REMOVE: begin
          wr_en = present_q[k_q] && !rm_clear;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign rd_addr  = (state_q == ST_DUMP) ? scan_idx_q : k_q;
  assign dump_hit = scan_vld_q && present_q[scan_prev_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[k_q] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= frh_pkg::CMD_ADD;
      size_q       <= '0;
      k_q          <= '0;
      present_q    <= '0;
      scan_idx_q   <= '0;
      scan_prev_q  <= '0;
      scan_vld_q   <= 1'b0;
      pend_vld_q   <= 1'b0;
      pend_idx_q   <= '0;
      pend_total_q <= '0;
      res_vld_q    <= 1'b0;
      res_label_q  <= '0;
      res_total_q  <= '0;
      res_last_q   <= 1'b0;
      res_empty_q  <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;

      // a present bin seen in the walk: release the one held before it
      if ((state_q == ST_DUMP || state_q == ST_DTAIL) && dump_hit) begin
        if (pend_vld_q) begin
          res_vld_q   <= 1'b1;
          res_label_q <= frh_pkg::bin_label(frh_pkg::KW'(pend_idx_q));
          res_total_q <= pend_total_q;
          res_last_q  <= 1'b0;
          res_empty_q <= 1'b0;
        end
        pend_vld_q   <= 1'b1;
        pend_idx_q   <= scan_prev_q;
        pend_total_q <= rd_data_q;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            size_q <= tx_size_i;
            case (command_i)
              frh_pkg::CMD_ADD: begin
                cmd_q   <= frh_pkg::CMD_ADD;
                state_q <= ST_DIV;
              end
              frh_pkg::CMD_REMOVE: begin
                cmd_q   <= frh_pkg::CMD_REMOVE;
                state_q <= ST_DIV;
              end
              frh_pkg::CMD_DUMP: begin
                cmd_q      <= frh_pkg::CMD_DUMP;
                scan_idx_q <= '0;
                scan_vld_q <= 1'b0;
                pend_vld_q <= 1'b0;
                state_q    <= ST_DUMP;
              end
              default: begin
                // unused code, dropped
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            k_q     <= div_bin;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          case (cmd_q)
            frh_pkg::CMD_ADD: begin
              present_q[k_q] <= 1'b1;
            end
            frh_pkg::CMD_REMOVE: begin
              if (present_q[k_q] && rm_clear) begin
                present_q[k_q] <= 1'b0;
              end
            end
            default: begin
              present_q <= present_q;
            end
          endcase
          state_q <= ST_IDLE;
        end
        ST_DUMP: begin
          scan_prev_q <= scan_idx_q;
          scan_vld_q  <= 1'b1;
          if (scan_idx_q == BinW'(NUM_BINS - 1)) begin
            state_q <= ST_DTAIL;
          end else begin
            scan_idx_q <= scan_idx_q + BinW'(1);
          end
        end
        ST_DTAIL: begin
          scan_vld_q <= 1'b0;
          state_q    <= ST_DFIN;
        end
        ST_DFIN: begin
          res_vld_q <= 1'b1;
          res_last_q <= 1'b1;
          if (pend_vld_q) begin
            res_label_q <= frh_pkg::bin_label(frh_pkg::KW'(pend_idx_q));
            res_total_q <= pend_total_q;
            res_empty_q <= 1'b0;
          end else begin
            // nothing present: single empty marker
            res_label_q <= '0;
            res_total_q <= '0;
            res_empty_q <= 1'b1;
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign res_total_w    = 64'(res_total_q);
  assign result_valid_o = res_vld_q;
  assign bucket_label_o = res_label_q;
  assign bucket_total_o = res_total_w[frh_pkg::OUT_TOTAL_BITS-1:0];
  assign is_last_o      = res_last_q;
  assign is_empty_o     = res_empty_q;

  `FRH_ASSERT(a_empty_is_last, (result_valid_o && is_empty_o) |-> is_last_o, "empty result not last")
  `FRH_ASSERT(a_dump_goes_busy, (accept && command_i == frh_pkg::CMD_DUMP) |=> busy, "dump not started")
  `FRH_ASSERT(a_div_done_in_div, div_done |-> (state_q == ST_DIV), "divider done outside wait")
  `FRH_ASSERT(a_no_result_on_update, (state_q == ST_UPD) |=> !result_valid_o, "result from an update")
  `FRH_ASSERT_NR(a_reset_quiet, !rst_ni |-> (!result_valid_o && !busy), "activity in reset")

endmodule

/* sv/frh_rate_bin.sv */
// serial fee / size division that yields the bit width of the rate as a bin
`timescale 1ns / 1ps

module frh_rate_bin #(
  parameter int unsigned NUM_BINS  = frh_pkg::DEF_NUM_BINS,
  parameter int unsigned SIZE_BITS = frh_pkg::DEF_SIZE_BITS,
  localparam int unsigned BinW     = $clog2(NUM_BINS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [frh_pkg::FEE_BITS-1:0]  fee_i,
  input  logic [SIZE_BITS-1:0]          size_i,
  output logic                          done_o,
  output logic [BinW-1:0]               bin_o
);

  localparam int unsigned FracW = frh_pkg::FEE_BITS - 1;

  logic                        run_q;
  logic [FracW-1:0]            fee_sh_q;
  logic [SIZE_BITS-1:0]        rem_q;
  logic [SIZE_BITS-1:0]        div_q;
  logic [frh_pkg::CNT_W-1:0]   cnt_q;
  logic                        done_q;
  logic [BinW-1:0]             bin_q;

  logic [SIZE_BITS:0]          shifted;
  logic                        hit;
  logic [frh_pkg::KW-1:0]      k_full;
  logic [frh_pkg::KW-1:0]      k_sat;

  // restoring step; stops at the first quotient one, whose place gives the width
  assign shifted = {rem_q, fee_sh_q[FracW-1]};
  assign hit     = shifted >= {1'b0, div_q};
  assign k_full  = frh_pkg::KW'(cnt_q) + frh_pkg::KW'(1);
  assign k_sat   = (k_full > frh_pkg::KW'(NUM_BINS - 1)) ? frh_pkg::KW'(NUM_BINS - 1) : k_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      fee_sh_q <= '0;
      rem_q    <= '0;
      div_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      bin_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (fee_i[frh_pkg::FEE_BITS-1]) begin
          // negative fee, rate below zero
          done_q <= 1'b1;
          bin_q  <= '0;
        end else begin
          run_q    <= 1'b1;
          fee_sh_q <= fee_i[FracW-1:0];
          rem_q    <= '0;
          div_q    <= (size_i == '0) ? SIZE_BITS'(1) : size_i;
          cnt_q    <= frh_pkg::CNT_W'(FracW - 1);
        end
      end else if (run_q) begin
        if (hit) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
          bin_q  <= k_sat[BinW-1:0];
        end else if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
          bin_q  <= '0;
        end else begin
          rem_q    <= shifted[SIZE_BITS-1:0];
          fee_sh_q <= {fee_sh_q[FracW-2:0], 1'b0};
          cnt_q    <= cnt_q - frh_pkg::CNT_W'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign bin_o  = bin_q;

endmodule
